// ===== rtl/dvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dvt_pkg: shared types and constants of the dual VFO tuner
// Mode codes, register indexes, reset values, command and result records.
// ----------------------------------------------------------------------------
package dvt_pkg;

	// Input mode codes
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_UP     = 3'd1;
	localparam logic [2:0] MODE_DOWN   = 3'd2;
	localparam logic [2:0] MODE_SELECT = 3'd3;
	localparam logic [2:0] MODE_LOAD   = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] REG_SQUELCH  = 3'd0;
	localparam logic [2:0] REG_STEP     = 3'd1;
	localparam logic [2:0] REG_VHF_MIN  = 3'd2;
	localparam logic [2:0] REG_VHF_MAX  = 3'd3;
	localparam logic [2:0] REG_UHF_MIN  = 3'd4;
	localparam logic [2:0] REG_UHF_MAX  = 3'd5;
	localparam logic [2:0] REG_DEBOUNCE = 3'd6;

	// Reset values of the registers
	localparam int unsigned MHZ_SCALE   = 1000000;
	localparam int unsigned VHF_MIN_MHZ = 136;
	localparam int unsigned VHF_MAX_MHZ = 174;
	localparam int unsigned UHF_MIN_MHZ = 400;
	localparam int unsigned UHF_MAX_MHZ = 480;

	localparam logic [7:0]  SQUELCH_RST  = 8'd0;
	localparam logic [23:0] STEP_RST     = 24'd12500;
	localparam logic [31:0] VHF_MIN_RST  = 32'(VHF_MIN_MHZ * MHZ_SCALE);
	localparam logic [31:0] VHF_MAX_RST  = 32'(VHF_MAX_MHZ * MHZ_SCALE);
	localparam logic [31:0] UHF_MIN_RST  = 32'(UHF_MIN_MHZ * MHZ_SCALE);
	localparam logic [31:0] UHF_MAX_RST  = 32'(UHF_MAX_MHZ * MHZ_SCALE);
	localparam logic [15:0] DEBOUNCE_RST = 16'd100;

	// Command classes produced by the front end
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_TICK,
		CMD_UP,
		CMD_DOWN,
		CMD_SELECT,
		CMD_LOAD
	} cmd_kind_t;

	typedef struct packed {
		logic [7:0]  squelch_level;
		logic [23:0] step_hz;
		logic [31:0] vhf_min_hz;
		logic [31:0] vhf_max_hz;
		logic [31:0] uhf_min_hz;
		logic [31:0] uhf_max_hz;
		logic [15:0] debounce_ms;
	} cfg_t;

	// hz carries readback_hz for a tick and load_hz for a load
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] now_ms;
		logic [7:0]  signal_level;
		logic        squelch_open;
		logic        tune_failed;
		logic        readback_valid;
		logic [31:0] hz;
		logic        vfo_index;
	} cmd_t;

	typedef struct packed {
		logic [31:0] frequency_hz;
		logic        current_vfo;
		logic [7:0]  rssi;
		logic        squelch_is_open;
		logic        pending_out;
		logic        program_strobe;
		logic [31:0] program_hz;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/dual_vfo_tuner_with_debounced_retune.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_vfo_tuner_with_debounced_retune: two-VFO tuner, debounced retune
// Throughput: one request per cycle unless a full result queue is not popped.
// Path: command queue, execute stage, then a registered result queue.
// Reset: registers to defaults, VFOs zero on A, retune armed, queues empty.
// ----------------------------------------------------------------------------
module dual_vfo_tuner_with_debounced_retune (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// requests
	input  logic        push,
	output logic        full,
	input  logic [2:0]  mode,
	input  logic [31:0] now_ms,
	input  logic [7:0]  signal_level,
	input  logic [7:0]  noise_level,
	input  logic        tune_failed,
	input  logic        readback_valid,
	input  logic [31:0] readback_hz,
	input  logic        vfo_index,
	input  logic [31:0] load_hz,
	// results
	output logic        empty,
	input  logic        pop,
	output logic [31:0] frequency_hz,
	output logic        current_vfo,
	output logic [7:0]  rssi,
	output logic        squelch_is_open,
	output logic        pending_out,
	output logic        program_strobe,
	output logic [31:0] program_hz
);
	import dvt_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;
	res_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.squelch_level <= SQUELCH_RST;
			cfg_q.step_hz       <= STEP_RST;
			cfg_q.vhf_min_hz    <= VHF_MIN_RST;
			cfg_q.vhf_max_hz    <= VHF_MAX_RST;
			cfg_q.uhf_min_hz    <= UHF_MIN_RST;
			cfg_q.uhf_max_hz    <= UHF_MAX_RST;
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SQUELCH:  cfg_q.squelch_level <= cfg_data[7:0];
				REG_STEP:     cfg_q.step_hz       <= cfg_data[23:0];
				REG_VHF_MIN:  cfg_q.vhf_min_hz    <= cfg_data;
				REG_VHF_MAX:  cfg_q.vhf_max_hz    <= cfg_data;
				REG_UHF_MIN:  cfg_q.uhf_min_hz    <= cfg_data;
				REG_UHF_MAX:  cfg_q.uhf_max_hz    <= cfg_data;
				REG_DEBOUNCE: cfg_q.debounce_ms   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Intake and classification
	dvt_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.push           (push),
		.full           (full),
		.mode           (mode),
		.now_ms         (now_ms),
		.signal_level   (signal_level),
		.noise_level    (noise_level),
		.tune_failed    (tune_failed),
		.readback_valid (readback_valid),
		.readback_hz    (readback_hz),
		.vfo_index      (vfo_index),
		.load_hz        (load_hz),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_take       (cmd_take)
	);

	// Execute stage
	dvt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	// Result fields
	assign frequency_hz    = res.frequency_hz;
	assign current_vfo     = res.current_vfo;
	assign rssi            = res.rssi;
	assign squelch_is_open = res.squelch_is_open;
	assign pending_out     = res.pending_out;
	assign program_strobe  = res.program_strobe;
	assign program_hz      = res.program_hz;

endmodule
`default_nettype wire

// ===== rtl/dvt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dvt_front: request intake and classification
// Decodes the mode, folds the squelch compare, and holds commands in a
// two-entry queue toward the execute stage.
// ----------------------------------------------------------------------------
module dvt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  dvt_pkg::cfg_t cfg,
	input  logic          push,
	output logic          full,
	input  logic [2:0]    mode,
	input  logic [31:0]   now_ms,
	input  logic [7:0]    signal_level,
	input  logic [7:0]    noise_level,
	input  logic          tune_failed,
	input  logic          readback_valid,
	input  logic [31:0]   readback_hz,
	input  logic          vfo_index,
	input  logic [31:0]   load_hz,
	output logic          cmd_valid,
	output dvt_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import dvt_pkg::*;

	cmd_t       cmd_in;
	cmd_t       mem_q [2];
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push_ok;
	logic       take_ok;

	// Classify the incoming request
	always_comb begin
		cmd_in                = '0;
		cmd_in.now_ms         = now_ms;
		cmd_in.signal_level   = signal_level;
		cmd_in.squelch_open   = noise_level < cfg.squelch_level;
		cmd_in.tune_failed    = tune_failed;
		cmd_in.readback_valid = readback_valid;
		cmd_in.vfo_index      = vfo_index;
		cmd_in.hz             = readback_hz;
		unique case (mode)
			MODE_TICK:   cmd_in.kind = CMD_TICK;
			MODE_UP:     cmd_in.kind = CMD_UP;
			MODE_DOWN:   cmd_in.kind = CMD_DOWN;
			MODE_SELECT: cmd_in.kind = CMD_SELECT;
			MODE_LOAD: begin
				cmd_in.kind = CMD_LOAD;
				cmd_in.hz   = load_hz;
			end
			default:     cmd_in.kind = CMD_NOP;
		endcase
	end

	// Queue status
	assign full      = cnt_q[1];
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = mem_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign take_ok   = cmd_take && cmd_valid;

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push_ok) - 2'(take_ok);
			if (push_ok) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take_ok) begin
				rd_ptr_q <= !rd_ptr_q;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("command queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("command queue pointers disagree with count");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken from an empty queue");

endmodule
`default_nettype wire

// ===== rtl/dvt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dvt_back: tuner execute stage
// Holds the VFO state, applies one command per cycle while the result queue
// has room or is popped, and queues results in a two-entry output queue.
// ----------------------------------------------------------------------------
module dvt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  dvt_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  dvt_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          empty,
	input  logic          pop,
	output dvt_pkg::res_t res
);
	import dvt_pkg::*;

	// Tuner state
	logic [31:0] vfo_q [2];
	logic        active_q;
	logic        pending_q;
	logic [31:0] last_q;
	logic [7:0]  rssi_q;
	logic        squelch_q;

	// Next state
	logic [31:0] vfo_n [2];
	logic        active_n;
	logic        pending_n;
	logic [31:0] last_n;
	logic [7:0]  rssi_n;
	logic        squelch_n;
	logic        strobe;
	logic [31:0] target;
	res_t        res_n;

	// Step datapath
	logic [31:0] cur_hz;
	logic        up;
	logic [32:0] sum;
	logic [32:0] nx;
	logic [31:0] lim;
	logic [31:0] elapsed;
	logic        due;

	// Result queue
	res_t       rq_q [2];
	logic [1:0] rq_cnt_q;
	logic       rq_wr_q;
	logic       rq_rd_q;
	logic       pop_ok;
	logic       fire;

	assign pop_ok   = pop && !empty;
	assign empty    = rq_cnt_q == 2'd0;
	assign fire     = cmd_valid && (rq_cnt_q != 2'd2 || pop_ok);
	assign cmd_take = fire;
	assign res      = rq_q[rq_rd_q];

	// Step with band limiting; up sum kept at 33 bits
	assign cur_hz = vfo_q[active_q];
	assign up     = cmd.kind == CMD_UP;
	assign sum    = {1'b0, cur_hz} + {9'b0, cfg.step_hz};
	always_comb begin
		if (up) begin
			nx = sum;
		end else if (cur_hz > {8'b0, cfg.step_hz}) begin
			nx = {1'b0, cur_hz - {8'b0, cfg.step_hz}};
		end else begin
			nx = {1'b0, cur_hz};
		end
		if (nx >= {1'b0, cfg.vhf_min_hz} && nx <= {1'b0, cfg.vhf_max_hz}) begin
			lim = nx[31:0];
		end else if (nx >= {1'b0, cfg.uhf_min_hz} && nx <= {1'b0, cfg.uhf_max_hz}) begin
			lim = nx[31:0];
		end else if (nx < {1'b0, cfg.vhf_min_hz}) begin
			lim = cfg.vhf_min_hz;
		end else if (nx > {1'b0, cfg.uhf_max_hz}) begin
			lim = cfg.uhf_max_hz;
		end else begin
			lim = up ? cfg.uhf_min_hz : cfg.vhf_max_hz;
		end
	end

	// Debounce window, wrapping difference
	assign elapsed = cmd.now_ms - last_q;
	assign due     = elapsed >= {16'b0, cfg.debounce_ms};

	// Command execution
	always_comb begin
		vfo_n[0]  = vfo_q[0];
		vfo_n[1]  = vfo_q[1];
		active_n  = active_q;
		pending_n = pending_q;
		last_n    = last_q;
		rssi_n    = rssi_q;
		squelch_n = squelch_q;
		strobe    = 1'b0;
		target    = 32'd0;
		unique case (cmd.kind)
			CMD_TICK: begin
				rssi_n    = cmd.signal_level;
				squelch_n = cmd.squelch_open;
				if (pending_q) begin
					if (due) begin
						target    = cur_hz;
						strobe    = 1'b1;
						pending_n = 1'b0;
						if (cmd.tune_failed && cmd.readback_valid) begin
							vfo_n[active_q] = cmd.hz;
						end
					end
				end else if (cmd.readback_valid) begin
					vfo_n[active_q] = cmd.hz;
				end
			end
			CMD_UP, CMD_DOWN: begin
				vfo_n[active_q] = lim;
				pending_n       = 1'b1;
				last_n          = cmd.now_ms;
			end
			CMD_SELECT: begin
				active_n  = cmd.vfo_index;
				pending_n = 1'b1;
				last_n    = cmd.now_ms;
			end
			CMD_LOAD: begin
				vfo_n[cmd.vfo_index] = cmd.hz;
				pending_n            = 1'b1;
				last_n               = cmd.now_ms;
			end
			CMD_NOP: begin
			end
			default: begin
			end
		endcase
		res_n.frequency_hz    = vfo_n[active_n];
		res_n.current_vfo     = active_n;
		res_n.rssi            = rssi_n;
		res_n.squelch_is_open = squelch_n;
		res_n.pending_out     = pending_n;
		res_n.program_strobe  = strobe;
		res_n.program_hz      = target;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vfo_q[0]  <= 32'd0;
			vfo_q[1]  <= 32'd0;
			active_q  <= 1'b0;
			pending_q <= 1'b1;
			last_q    <= 32'd0;
			rssi_q    <= 8'd0;
			squelch_q <= 1'b0;
		end else if (fire) begin
			vfo_q[0]  <= vfo_n[0];
			vfo_q[1]  <= vfo_n[1];
			active_q  <= active_n;
			pending_q <= pending_n;
			last_q    <= last_n;
			rssi_q    <= rssi_n;
			squelch_q <= squelch_n;
		end
	end

	// Result queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_cnt_q <= 2'd0;
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
		end else begin
			rq_cnt_q <= rq_cnt_q + 2'(fire) - 2'(pop_ok);
			if (fire) begin
				rq_wr_q <= !rq_wr_q;
			end
			if (pop_ok) begin
				rq_rd_q <= !rq_rd_q;
			end
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (fire) begin
			rq_q[rq_wr_q] <= res_n;
		end
	end

	// Checks
	a_rq_range: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_strobe_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && strobe |=> !pending_q)
		else $error("retune still pending after program request");

	a_change_arms: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd.kind == CMD_UP || cmd.kind == CMD_DOWN ||
			cmd.kind == CMD_SELECT || cmd.kind == CMD_LOAD) |=> pending_q)
		else $error("tuning change did not arm a retune");

endmodule
`default_nettype wire
